// ----- rtl/core/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned HeldDepth = 3;  // last byte of a sequence is never stored

  // Sequence lengths
  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  // Replacement character '?'
  localparam logic [CpWidth-1:0] Replacement = 21'h00003F;

  // Decoder sequence state
  typedef struct packed {
    logic [2:0] needed;  // total length of open sequence, 0 when none
    logic [1:0] count;   // bytes gathered so far
  } seq_state_t;

  // Per-item decode outcome
  typedef struct packed {
    logic               res_valid;
    logic [CpWidth-1:0] code_point;
    logic               is_error;
    logic               wr_en;
    logic [1:0]         wr_idx;
    seq_state_t         state_next;
  } dec_out_t;

endpackage

// ----- rtl/core/utf8d_decode.sv -----
// ----------------------------------------------------------------------------
// utf8d_decode
// Combinational decode of one byte against the open sequence state.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic                                                   enabled,
  input  logic [utf8d_pkg::ByteWidth-1:0]                        in_byte,
  input  utf8d_pkg::seq_state_t                                  state,
  input  logic [utf8d_pkg::HeldDepth-1:0][utf8d_pkg::ByteWidth-1:0] held,
  output utf8d_pkg::dec_out_t                                    dec
);

  logic [2:0] count_inc;

  assign count_inc = {1'b0, state.count} + 3'd1;

  always_comb begin
    dec            = '0;
    dec.state_next = state;
    if (enabled) begin
      if (state.needed == utf8d_pkg::LenNone) begin
        // no sequence open: ASCII, lead byte or bad lead
        if (in_byte[7] == 1'b0) begin
          dec.res_valid  = 1'b1;
          dec.code_point = {13'd0, in_byte};
        end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
                     in_byte[7:3] == 5'b11110) begin
          dec.wr_en            = 1'b1;
          dec.wr_idx           = 2'd0;
          dec.state_next.count = 2'd1;
          if (in_byte[7:5] == 3'b110) begin
            dec.state_next.needed = utf8d_pkg::LenTwo;
          end else if (in_byte[7:4] == 4'b1110) begin
            dec.state_next.needed = utf8d_pkg::LenThree;
          end else begin
            dec.state_next.needed = utf8d_pkg::LenFour;
          end
        end else begin
          dec.res_valid  = 1'b1;
          dec.code_point = utf8d_pkg::Replacement;
          dec.is_error   = 1'b1;
        end
      end else if (in_byte[7:6] != 2'b10) begin
        // broken sequence: drop it and discard this byte
        dec.res_valid  = 1'b1;
        dec.code_point = utf8d_pkg::Replacement;
        dec.is_error   = 1'b1;
        dec.state_next = '0;
      end else if (count_inc >= state.needed) begin
        // last continuation byte: assemble with current byte as the tail
        dec.res_valid  = 1'b1;
        dec.state_next = '0;
        case (state.needed)
          utf8d_pkg::LenTwo: begin
            dec.code_point = {10'd0, held[0][4:0], in_byte[5:0]};
          end
          utf8d_pkg::LenThree: begin
            dec.code_point = {5'd0, held[0][3:0], held[1][5:0], in_byte[5:0]};
          end
          default: begin
            dec.code_point = {held[0][2:0], held[1][5:0], held[2][5:0], in_byte[5:0]};
          end
        endcase
      end else begin
        // middle continuation byte: store it
        dec.wr_en            = 1'b1;
        dec.wr_idx           = state.count;
        dec.state_next.count = count_inc[1:0];
      end
    end
  end

endmodule

// ----- rtl/core/utf8_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_byte_decoder
// UTF-8 byte stream to code point decoder, one byte per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Takes one byte per item and returns a code point when a character is
// complete: ASCII at once, 2 to 4 byte sequences with their last byte, and
// '?' flagged by is_error for a bad lead or a broken sequence (the breaking
// byte is dropped). Overlong forms and surrogates are not checked. A byte is
// taken every clock unless the output stalls; each item is caught in an input
// register, decoded, and written to the result register when that is free,
// so a result is offered from the result register after its byte has passed
// the input register. Results wait in the output register while the next
// byte is taken. Write output_enabled through cfg_we/cfg_wdata only while
// idle; with it low every byte is dropped and the sequence state is kept.
module utf8_byte_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [utf8d_pkg::ByteWidth-1:0]     in_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [utf8d_pkg::CpWidth-1:0]       code_point,
  output logic                                is_error
);

  logic                                                      enabled;
  logic                                                      s1_valid;
  logic [utf8d_pkg::ByteWidth-1:0]                           s1_byte;
  utf8d_pkg::seq_state_t                                     state;
  logic [utf8d_pkg::HeldDepth-1:0][utf8d_pkg::ByteWidth-1:0] held;
  logic [utf8d_pkg::CpWidth-1:0]                             out_cp;
  logic                                                      out_err;
  utf8d_pkg::dec_out_t                                       dec;
  logic                                                      advance;
  logic                                                      in_take;

  // handshake
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_take   = in_valid && !in_stall;
  assign code_point = out_cp;
  assign is_error   = out_err;

  utf8d_decode u_decode (
    .enabled (enabled),
    .in_byte (s1_byte),
    .state   (state),
    .held    (held),
    .dec     (dec)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= 1'b1;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (cfg_we) begin
        enabled <= cfg_wdata;
      end
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= dec.res_valid;
        state     <= dec.state_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= in_byte;
    end
    if (advance && dec.res_valid) begin
      out_cp  <= dec.code_point;
      out_err <= dec.is_error;
    end
    if (advance && dec.wr_en) begin
      case (dec.wr_idx)
        2'd0:    held[0] <= s1_byte;
        2'd1:    held[1] <= s1_byte;
        2'd2:    held[2] <= s1_byte;
        default: held[0] <= held[0];
      endcase
    end
  end

endmodule

// ----- tb/utf8_byte_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_decoder_tb
// Self-checking testbench for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
// Drives byte items through the valid/stall input channel and checks every
// code point that leaves the output channel against a local decoder model
// kept in a small scoreboard class. A short directed list covers ASCII,
// every sequence length, bad leads, broken sequences and the disabled mode;
// the random part is mostly well-formed sequences with random payload bits,
// mixed with bad leads, broken sequences and raw noise bytes. Sender gaps
// and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module utf8_byte_decoder_tb;

  localparam int HoldCycles  = 80;   // long receiver hold-off
  localparam int DrainCycles = 6;    // pipeline is two deep, leave margin
  localparam int MaxReports  = 10;

  // Directed bytes: ASCII ends, 2/3/4 byte forms incl. top code point,
  // bad leads, breaks by ASCII and by a lead, accepted overlong form
  localparam logic [utf8d_pkg::ByteWidth-1:0] DirectedBytes [26] = '{
    8'h00, 8'h7F,
    8'hC2, 8'hA9,
    8'hE2, 8'h82, 8'hAC,
    8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'h80, 8'hBF, 8'hF8, 8'hFF,
    8'hE2, 8'h41,
    8'hF0, 8'h90, 8'hC3,
    8'hC0, 8'h80
  };

  typedef struct packed {
    logic [utf8d_pkg::CpWidth-1:0] code_point;
    logic                          is_error;
  } char_result_t;

  // Decoder model and queue of expected characters
  class char_scoreboard;
    char_result_t                    expected_q[$];
    bit                              enabled;
    logic [2:0]                      seq_len;
    logic [2:0]                      seq_cnt;
    logic [utf8d_pkg::ByteWidth-1:0] seq_bytes [4];
    int                              errors;

    function new();
      enabled = 1'b1;
      seq_len = utf8d_pkg::LenNone;
      seq_cnt = 3'd0;
      errors  = 0;
    endfunction

    function void push_char(logic [utf8d_pkg::CpWidth-1:0] cp, logic err);
      char_result_t r;
      r.code_point = cp;
      r.is_error   = err;
      expected_q.push_back(r);
    endfunction

    function logic [utf8d_pkg::CpWidth-1:0] assemble_char();
      case (seq_len)
        utf8d_pkg::LenTwo:
          return {10'd0, seq_bytes[0][4:0], seq_bytes[1][5:0]};
        utf8d_pkg::LenThree:
          return {5'd0, seq_bytes[0][3:0], seq_bytes[1][5:0], seq_bytes[2][5:0]};
        default:
          return {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0],
                  seq_bytes[3][5:0]};
      endcase
    endfunction

    // Called for every accepted input item
    function void note_input(logic [utf8d_pkg::ByteWidth-1:0] b);
      logic [2:0] len;
      if (!enabled) return;
      if (seq_len == utf8d_pkg::LenNone) begin
        len = utf8d_pkg::LenNone;
        if (b[7:5] == 3'b110)        len = utf8d_pkg::LenTwo;
        else if (b[7:4] == 4'b1110)  len = utf8d_pkg::LenThree;
        else if (b[7:3] == 5'b11110) len = utf8d_pkg::LenFour;
        if (!b[7]) begin
          push_char({13'd0, b}, 1'b0);
        end else if (len == utf8d_pkg::LenNone) begin
          push_char(utf8d_pkg::Replacement, 1'b1);
        end else begin
          seq_len      = len;
          seq_bytes[0] = b;
          seq_cnt      = 3'd1;
        end
      end else if (b[7:6] != 2'b10) begin
        // broken sequence: drop it, the breaking byte is discarded too
        seq_len = utf8d_pkg::LenNone;
        seq_cnt = 3'd0;
        push_char(utf8d_pkg::Replacement, 1'b1);
      end else begin
        seq_bytes[seq_cnt[1:0]] = b;
        seq_cnt = seq_cnt + 3'd1;
        if (seq_cnt >= seq_len) begin
          push_char(assemble_char(), 1'b0);
          seq_len = utf8d_pkg::LenNone;
          seq_cnt = 3'd0;
        end
      end
    endfunction

    function void log_error(string msg);
      errors++;
      if (errors <= MaxReports) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // Called for every accepted result item
    function void check_result(logic [utf8d_pkg::CpWidth-1:0] cp, logic err);
      char_result_t exp_r;
      if (expected_q.size() == 0) begin
        log_error($sformatf("unexpected result code_point=%06h is_error=%0b", cp, err));
      end else begin
        exp_r = expected_q.pop_front();
        if (cp !== exp_r.code_point)
          log_error($sformatf("code_point expected %06h got %06h", exp_r.code_point, cp));
        if (err !== exp_r.is_error)
          log_error($sformatf("is_error expected %0b got %0b", exp_r.is_error, err));
      end
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic                            cfg_wdata = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic [utf8d_pkg::ByteWidth-1:0] in_byte   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [utf8d_pkg::CpWidth-1:0]   code_point;
  logic                            is_error;

  char_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;   // bumped by the stimulus to ask for a hold-off
  int hold_ack      = 0;
  int hold_left     = 0;

  utf8_byte_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .is_error   (is_error)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Monitor both channels and drive the receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(code_point, is_error);
    if (!rst && in_valid && !in_stall) sb.note_input(in_byte);
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one item and wait until it is taken
  task automatic send_byte(input logic [utf8d_pkg::ByteWidth-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_output_enabled(input bit v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    sb.enabled = v;
  endtask

  function automatic logic [utf8d_pkg::ByteWidth-1:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [utf8d_pkg::ByteWidth-1:0] lead_byte(input int n);
    case (n)
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  // One random group: ASCII, a full sequence, a bad lead, a broken
  // sequence or a raw noise byte
  task automatic send_random_group(output int sent);
    int kind;
    int n;
    int k;
    logic [utf8d_pkg::ByteWidth-1:0] b;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_byte(8'($urandom_range(127)));
      sent = 1;
    end else if (kind < 75) begin
      n = (kind < 40) ? 2 : (kind < 60) ? 3 : 4;
      send_byte(lead_byte(n));
      repeat (n - 1) send_byte(cont_byte());
      sent = n;
    end else if (kind < 82) begin
      b = $urandom_range(1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)};
      send_byte(b);
      sent = 1;
    end else if (kind < 92) begin
      n = $urandom_range(4, 2);
      k = $urandom_range(n - 2, 0);
      send_byte(lead_byte(n));
      repeat (k) send_byte(cont_byte());
      b = 8'($urandom);
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      send_byte(b);
      sent = k + 2;
    end else begin
      send_byte(8'($urandom));
      sent = 1;
    end
  endtask

  // Random phase; with pressure, a long hold-off and a full pause mid-way
  task automatic run_random(input int n_items, input bit with_pressure);
    int count;
    int sent;
    bit held;
    bit paused;
    count  = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (count < n_items) begin
      send_random_group(sent);
      count += sent;
      if (with_pressure && !held && count >= n_items / 3) begin
        hold_req <= hold_req + 1;
        held = 1'b1;
      end
      if (with_pressure && !paused && count >= 2 * n_items / 3) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, decoding on from reset
    foreach (DirectedBytes[i]) send_byte(DirectedBytes[i]);

    // sequence left open across a disabled stretch
    send_byte(8'hE2);
    send_byte(8'h82);
    set_output_enabled(1'b0);
    send_byte(8'h41);
    send_byte(8'hC3);
    send_byte(8'hFF);
    set_output_enabled(1'b1);
    send_byte(8'hAC);

    // no idling, with hold-off and pause
    run_random(400, 1'b1);

    // sender mostly idle
    wait_drained();
    send_idle_pct = 88;
    stall_pct     = 0;
    run_random(350, 1'b0);

    // disabled: every byte is dropped
    set_output_enabled(1'b0);
    send_idle_pct = 12;
    stall_pct     = 12;
    run_random(60, 1'b0);
    set_output_enabled(1'b1);

    // receiver mostly stalling
    send_idle_pct = 0;
    stall_pct     = 88;
    run_random(350, 1'b0);

    // both idle now and then
    send_idle_pct = 12;
    stall_pct     = 12;
    run_random(350, 1'b0);

    stall_pct = 0;
    wait_drained();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_decode.sv
rtl/core/utf8_byte_decoder.sv
tb/utf8_byte_decoder_tb.sv
